// ----- hw/rtl/bts_pkg.sv -----
// ============================================================================
// bts_pkg
// Request/result payload types and request codes for the bilinear texel sampler
// ============================================================================
`default_nettype none

package bts_pkg;

    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_READ     = 2'd1;
    localparam logic [1:0] REQ_SAMPLE   = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic [16:0]        sample_u;
        logic [16:0]        sample_v;
        logic [7:0]         write_red;
        logic [7:0]         write_green;
        logic [7:0]         write_blue;
        logic [7:0]         write_alpha;
    } req_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
    } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bilinear_texel_sampler.sv -----
// ============================================================================
// bilinear_texel_sampler
// RGBA8 texel store with clamped read and bilinear sample, Q8.8 results
// ============================================================================
//  channel   | signals                        | direction
//  request   | req, req_valid, req_stall      | in
//  result    | res, res_valid, res_stall      | out
//  config    | cfg_index, cfg_data, cfg_valid, cfg_ready | in
//
//  one request per cycle unless stalled; results pass front, s1, s2 and output regs
//  the texel store is four copies of one memory, one per neighbour read port
//  no clearing pass after reset: texels are undefined until written
//  a stalled result freezes the back pipe, which in turn stalls the front
// ============================================================================
`default_nettype none

module bilinear_texel_sampler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bts_pkg::req_t req,
    input  wire logic          req_valid,
    output logic               req_stall,
    output bts_pkg::res_t      res,
    output logic               res_valid,
    input  wire logic          res_stall,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [8:0]    cfg_data
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [8:0] width_reg, height_reg;
    logic f_valid, f_stall, f_wr, f_smp;
    logic [XW-1:0] f_x1, f_x2;
    logic [YW-1:0] f_y1, f_y2;
    logic [7:0] f_fx, f_fy;
    logic [31:0] f_data;

    assign cfg_ready = 1'b1;

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == bts_pkg::CFG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    bts_front #(.XW(XW), .YW(YW), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid), .req_stall(req_stall),
        .width_reg_in(width_reg), .height_reg_in(height_reg),
        .f_valid(f_valid), .f_stall(f_stall), .f_wr(f_wr), .f_smp(f_smp),
        .f_x1(f_x1), .f_x2(f_x2), .f_y1(f_y1), .f_y2(f_y2),
        .f_fx(f_fx), .f_fy(f_fy), .f_data(f_data)
    );

    bts_back #(.XW(XW), .YW(YW)) u_back (
        .clk(clk), .rst_n(rst_n), .f_valid(f_valid), .f_stall(f_stall),
        .f_wr(f_wr), .f_smp(f_smp), .f_x1(f_x1), .f_x2(f_x2), .f_y1(f_y1), .f_y2(f_y2),
        .f_fx(f_fx), .f_fy(f_fy), .f_data(f_data),
        .res(res), .res_valid(res_valid), .res_stall(res_stall)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/bts_front.sv -----
// ============================================================================
// bts_front
// Classifies requests and works out clamped texel coordinates and fractions
// ============================================================================
`default_nettype none

module bts_front #(
    parameter int XW = 8,
    parameter int YW = 8,
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bts_pkg::req_t     req,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic [8:0]        width_reg_in,
    input  wire logic [8:0]        height_reg_in,
    // to back: registered classified request
    output logic                   f_valid,
    input  wire logic              f_stall,
    output logic                   f_wr,
    output logic                   f_smp,
    output logic [XW-1:0]          f_x1,
    output logic [XW-1:0]          f_x2,
    output logic [YW-1:0]          f_y1,
    output logic [YW-1:0]          f_y2,
    output logic [7:0]             f_fx,
    output logic [7:0]             f_fy,
    output logic [31:0]            f_data
);
    localparam int SW = (XW > YW ? XW : YW) + 1;

    logic [SW-1:0] w_eff, h_eff;
    logic          acc;
    logic          is_wr, is_rd, is_smp, wr_ok;
    logic [XW-1:0] cx, sx1, sx2;
    logic [YW-1:0] cy, sy1, sy2;
    logic [7:0]    sfx, sfy;
    logic [16:0]   pu, pv;
    logic [SW+16:0] su, sv;

    logic          valid_reg;
    logic          wr_reg, smp_reg;
    logic [XW-1:0] x1_reg, x2_reg;
    logic [YW-1:0] y1_reg, y2_reg;
    logic [7:0]    fx_reg, fy_reg;
    logic [31:0]   data_reg;

    // effective sizes, 0 acts as 1 and above maximum as maximum
    always_comb
    begin
        if (width_reg_in == 9'd0)
            w_eff = SW'(1);
        else if (32'(width_reg_in) > MAX_WIDTH)
            w_eff = SW'(MAX_WIDTH);
        else
            w_eff = SW'(width_reg_in);
        if (height_reg_in == 9'd0)
            h_eff = SW'(1);
        else if (32'(height_reg_in) > MAX_HEIGHT)
            h_eff = SW'(MAX_HEIGHT);
        else
            h_eff = SW'(height_reg_in);
    end

    // classify
    assign is_wr  = req.req_type == bts_pkg::REQ_WRITE;
    assign is_rd  = req.req_type == bts_pkg::REQ_READ;
    assign is_smp = req.req_type == bts_pkg::REQ_SAMPLE;
    assign wr_ok  = !req.pixel_x[15] && !req.pixel_y[15]
                    && (32'(req.pixel_x) < 32'(w_eff)) && (32'(req.pixel_y) < 32'(h_eff));

    // clamp to edge for reads
    always_comb
    begin
        if (req.pixel_x[15])
            cx = '0;
        else if (32'(req.pixel_x) > 32'(w_eff) - 1)
            cx = XW'(w_eff - SW'(1));
        else
            cx = XW'(req.pixel_x);
        if (req.pixel_y[15])
            cy = '0;
        else if (32'(req.pixel_y) > 32'(h_eff) - 1)
            cy = YW'(h_eff - SW'(1));
        else
            cy = YW'(req.pixel_y);
    end

    // sample positions scaled by size minus one
    always_comb
    begin
        pu  = req.sample_u[16] ? 17'h10000 : req.sample_u;
        pv  = req.sample_v[16] ? 17'h10000 : req.sample_v;
        su  = (SW+17)'(pu) * (SW+17)'(w_eff - SW'(1));
        sv  = (SW+17)'(pv) * (SW+17)'(h_eff - SW'(1));
        sx1 = XW'(su >> 16);
        sy1 = YW'(sv >> 16);
        sfx = su[15:8];
        sfy = sv[15:8];
        sx2 = (32'(sx1) + 1 > 32'(w_eff) - 1) ? sx1 : XW'(32'(sx1) + 1);
        sy2 = (32'(sy1) + 1 > 32'(h_eff) - 1) ? sy1 : YW'(32'(sy1) + 1);
    end

    assign req_stall = valid_reg && f_stall;
    assign acc       = req_valid && !req_stall
                       && ((is_wr && wr_ok) || is_rd || is_smp);

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!req_stall)
            valid_reg <= acc;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            wr_reg   <= is_wr;
            smp_reg  <= is_smp;
            x1_reg   <= is_smp ? sx1 : (is_wr ? XW'(req.pixel_x) : cx);
            y1_reg   <= is_smp ? sy1 : (is_wr ? YW'(req.pixel_y) : cy);
            x2_reg   <= sx2;
            y2_reg   <= sy2;
            fx_reg   <= sfx;
            fy_reg   <= sfy;
            data_reg <= {req.write_alpha, req.write_blue, req.write_green, req.write_red};
        end
    end

    assign f_valid = valid_reg;
    assign f_wr    = wr_reg;
    assign f_smp   = smp_reg;
    assign f_x1    = x1_reg;
    assign f_x2    = x2_reg;
    assign f_y1    = y1_reg;
    assign f_y2    = y2_reg;
    assign f_fx    = fx_reg;
    assign f_fy    = fy_reg;
    assign f_data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bts_back.sv -----
// ============================================================================
// bts_back
// Replicated texel store, four-texel fetch, bilinear blend and output register
// ============================================================================
`default_nettype none

module bts_back #(
    parameter int XW = 8,
    parameter int YW = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              f_valid,
    output logic                   f_stall,
    input  wire logic              f_wr,
    input  wire logic              f_smp,
    input  wire logic [XW-1:0]     f_x1,
    input  wire logic [XW-1:0]     f_x2,
    input  wire logic [YW-1:0]     f_y1,
    input  wire logic [YW-1:0]     f_y2,
    input  wire logic [7:0]        f_fx,
    input  wire logic [7:0]        f_fy,
    input  wire logic [31:0]       f_data,
    output bts_pkg::res_t          res,
    output logic                   res_valid,
    input  wire logic              res_stall
);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    // four copies of the store, one per neighbour
    logic [31:0] mem11 [DEPTH];
    logic [31:0] mem21 [DEPTH];
    logic [31:0] mem12 [DEPTH];
    logic [31:0] mem22 [DEPTH];

    logic        adv, go, wr_en;
    logic        s1_valid_reg, s2_valid_reg, o_valid_reg;
    logic        s1_smp_reg, s2_smp_reg;
    logic [7:0]  s1_fx_reg, s1_fy_reg, s2_fy_reg;
    logic [31:0] t11_reg, t21_reg, t12_reg, t22_reg;
    logic [15:0] r1_reg [4];
    logic [15:0] r2_reg [4];
    logic [15:0] rd_reg [4];
    bts_pkg::res_t o_reg;
    bts_pkg::res_t blend;

    // whole pipe moves together when the output slot is free
    assign adv     = !(o_valid_reg && res_stall);
    assign f_stall = !adv;
    assign go      = f_valid && adv && !f_wr;
    assign wr_en   = f_valid && adv && f_wr;

    // texel store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem11[{f_y1, f_x1}] <= f_data;
            mem21[{f_y1, f_x1}] <= f_data;
            mem12[{f_y1, f_x1}] <= f_data;
            mem22[{f_y1, f_x1}] <= f_data;
        end
        if (go)
        begin
            t11_reg <= mem11[{f_y1, f_x1}];
            t21_reg <= mem21[{f_y1, f_x2}];
            t12_reg <= mem12[{f_y2, f_x1}];
            t22_reg <= mem22[{f_y2, f_x2}];
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_smp_reg <= f_smp;
            s1_fx_reg  <= f_fx;
            s1_fy_reg  <= f_fy;
        end
        if (adv && s1_valid_reg)
        begin
            s2_smp_reg <= s1_smp_reg;
            s2_fy_reg  <= s1_fy_reg;
            for (int c = 0; c < 4; c++)
            begin
                r1_reg[c] <= 16'(t11_reg[8*c +: 8] * (9'd256 - 9'(s1_fx_reg)))
                           + 16'(t21_reg[8*c +: 8] * s1_fx_reg);
                r2_reg[c] <= 16'(t12_reg[8*c +: 8] * (9'd256 - 9'(s1_fx_reg)))
                           + 16'(t22_reg[8*c +: 8] * s1_fx_reg);
                rd_reg[c] <= {t11_reg[8*c +: 8], 8'd0};
            end
        end
        if (adv && s2_valid_reg)
            o_reg <= blend;
    end

    // column blend
    always_comb
    begin
        logic [15:0] v [4];
        for (int c = 0; c < 4; c++)
            v[c] = s2_smp_reg
                ? 16'(((25'(r1_reg[c]) * (25'd256 - 25'(s2_fy_reg)))
                      + (25'(r2_reg[c]) * 25'(s2_fy_reg))) >> 8)
                : rd_reg[c];
        blend = '{out_red: v[0], out_green: v[1], out_blue: v[2], out_alpha: v[3]};
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= go;
            s2_valid_reg <= s1_valid_reg;
            o_valid_reg  <= s2_valid_reg;
        end
    end

    assign res       = o_reg;
    assign res_valid = o_valid_reg;

    // pipe freezes whole while the result waits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && res_stall) |=> (o_valid_reg && $stable(s2_valid_reg)))
        else $error("pipe moved under stall");
    a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !s1_valid_reg)
        else $error("write produced a result");
    a_go: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> s1_valid_reg)
        else $error("lost request");

endmodule

`default_nettype wire

// ----- sim/bts_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// bts_checker
// Watches the request, result and config channels of the texel sampler,
// keeps its own texel store and image size, predicts each read and sample
// result and compares it field by field with what comes out.
// ============================================================================
`default_nettype none

module bts_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bts_pkg::req_t req,
    input  wire logic          req_valid,
    input  wire logic          req_stall,
    input  wire bts_pkg::res_t res,
    input  wire logic          res_valid,
    input  wire logic          res_stall,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_ready,
    input  wire logic  [0:0]   cfg_index,
    input  wire logic  [8:0]   cfg_data,
    output int                 fails,
    output int                 pending
);

    localparam int MAX_W = 256;
    localparam int MAX_H = 256;

    logic [31:0]   texels [MAX_W*MAX_H];
    logic [8:0]    width_reg;
    logic [8:0]    height_reg;
    bts_pkg::res_t expected_q [$];

    initial
    begin
        fails = 0;
        pending = 0;
        width_reg = 9'd256;
        height_reg = 9'd256;
        foreach (texels[i]) texels[i] = '0;
    end

    // register value to effective size
    function automatic int eff_size(logic [8:0] r, int maxv);
        if (r == 0) return 1;
        if (int'(r) > maxv) return maxv;
        return int'(r);
    endfunction

    function automatic int clamp_axis(logic signed [15:0] c, int size);
        if (c < 0) return 0;
        if (int'(c) > size - 1) return size - 1;
        return int'(c);
    endfunction

    // Q1.16 position scaled by size-1: both neighbours and 8-bit fraction
    function automatic void scale_axis(logic [16:0] raw, int size,
                                       output int i1, output int i2,
                                       output int frac);
        int unsigned p;
        int unsigned s;
        p = (raw > 17'd65536) ? 65536 : raw;
        s = p * (size - 1);
        i1 = s >> 16;
        if (i1 > size - 1) i1 = size - 1;
        i2 = (i1 + 1 > size - 1) ? size - 1 : i1 + 1;
        frac = (s >> 8) & 8'hFF;
    endfunction

    function automatic bts_pkg::res_t clamped_texel(bts_pkg::req_t r, int w, int h);
        logic [31:0] t;
        bts_pkg::res_t o;
        t = texels[clamp_axis(r.pixel_y, h) * MAX_W + clamp_axis(r.pixel_x, w)];
        o.out_red   = {t[7:0], 8'h00};
        o.out_green = {t[15:8], 8'h00};
        o.out_blue  = {t[23:16], 8'h00};
        o.out_alpha = {t[31:24], 8'h00};
        return o;
    endfunction

    function automatic bts_pkg::res_t bilinear_blend(bts_pkg::req_t r, int w, int h);
        int x1, x2, fx, y1, y2, fy;
        logic [31:0] t11, t21, t12, t22;
        int unsigned r1, r2, v;
        logic [15:0] ch [4];
        bts_pkg::res_t o;
        scale_axis(r.sample_u, w, x1, x2, fx);
        scale_axis(r.sample_v, h, y1, y2, fy);
        t11 = texels[y1 * MAX_W + x1];
        t21 = texels[y1 * MAX_W + x2];
        t12 = texels[y2 * MAX_W + x1];
        t22 = texels[y2 * MAX_W + x2];
        for (int c = 0; c < 4; c++)
        begin
            r1 = t11[8*c +: 8] * (256 - fx) + t21[8*c +: 8] * fx;
            r2 = t12[8*c +: 8] * (256 - fx) + t22[8*c +: 8] * fx;
            v = (r1 * (256 - fy) + r2 * fy) >> 8;
            ch[c] = v[15:0];
        end
        o.out_red = ch[0];
        o.out_green = ch[1];
        o.out_blue = ch[2];
        o.out_alpha = ch[3];
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch %s", $time, msg);
        fails++;
    endtask

    // channel monitor
    always @(posedge clk)
    begin
        int w, h;
        bts_pkg::res_t want;
        if (rst_n)
        begin
            w = eff_size(width_reg, MAX_W);
            h = eff_size(height_reg, MAX_H);

            // accepted request
            if (req_valid && !req_stall)
            begin
                unique case (req.req_type)
                    bts_pkg::REQ_WRITE:
                        if (req.pixel_x >= 0 && req.pixel_y >= 0 &&
                            int'(req.pixel_x) < w && int'(req.pixel_y) < h)
                            texels[int'(req.pixel_y) * MAX_W + int'(req.pixel_x)] =
                                {req.write_alpha, req.write_blue,
                                 req.write_green, req.write_red};
                    bts_pkg::REQ_READ:   expected_q.push_back(clamped_texel(req, w, h));
                    bts_pkg::REQ_SAMPLE: expected_q.push_back(bilinear_blend(req, w, h));
                    default: ;
                endcase
            end

            // accepted result
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", res));
                else
                begin
                    want = expected_q.pop_front();
                    if (res.out_red !== want.out_red)
                        report_mismatch($sformatf("red: got %h expected %h",
                                                  res.out_red, want.out_red));
                    if (res.out_green !== want.out_green)
                        report_mismatch($sformatf("green: got %h expected %h",
                                                  res.out_green, want.out_green));
                    if (res.out_blue !== want.out_blue)
                        report_mismatch($sformatf("blue: got %h expected %h",
                                                  res.out_blue, want.out_blue));
                    if (res.out_alpha !== want.out_alpha)
                        report_mismatch($sformatf("alpha: got %h expected %h",
                                                  res.out_alpha, want.out_alpha));
                end
            end

            // register write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bts_pkg::CFG_WIDTH) width_reg = cfg_data;
                else height_reg = cfg_data;
            end
            pending = expected_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb
// Drives the texel sampler through a directed run on a 2x2 image and then
// random writes, clamped reads and bilinear samples over a series of image
// sizes, with random gaps and result stalls. Checking is done by bts_checker.
// ============================================================================
`default_nettype none

module tb;

    localparam int REQ_BITS = $bits(bts_pkg::req_t);

    logic          clk;
    logic          rst_n;
    bts_pkg::req_t req;
    logic          req_valid;
    logic          req_stall;
    bts_pkg::res_t res;
    logic          res_valid;
    logic          res_stall;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [0:0]    cfg_index;
    logic [8:0]    cfg_data;
    int            fails;
    int            pending;

    // texels written so far, and the size the block currently uses
    bit          texel_set [65536];
    int          cur_w;
    int          cur_h;
    bit          hold_off;
    bit          no_gaps;

    bilinear_texel_sampler DUT (
        .clk(clk), .rst_n(rst_n),
        .req(req), .req_valid(req_valid), .req_stall(req_stall),
        .res(res), .res_valid(res_valid), .res_stall(res_stall),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bts_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req(req), .req_valid(req_valid), .req_stall(req_stall),
        .res(res), .res_valid(res_valid), .res_stall(res_stall),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fails(fails), .pending(pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // result stall: random stretches, or one long hold-off on request
    initial
    begin
        int len;
        res_stall = 1'b0;
        hold_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                res_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                len = (($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
                                                     : $urandom_range(10, 50));
                res_stall <= ($urandom_range(0, 2) == 0);
                repeat (len) @(posedge clk);
            end
        end
    end

    function automatic int size_of(int r, int maxv);
        if (r == 0) return 1;
        return (r > maxv) ? maxv : r;
    endfunction

    // neighbours an axis position touches
    function automatic void axis_span(logic [16:0] raw, int size,
                                      output int lo, output int hi);
        int unsigned p;
        p = (raw > 17'd65536) ? 65536 : raw;
        lo = (p * (size - 1)) >> 16;
        if (lo > size - 1) lo = size - 1;
        hi = (lo + 1 > size - 1) ? size - 1 : lo + 1;
    endfunction

    function automatic bit is_set(int x, int y);
        return texel_set[y * 256 + x];
    endfunction

    function automatic int clamp_to(logic signed [15:0] c, int size);
        if (c < 0) return 0;
        return (int'(c) > size - 1) ? size - 1 : int'(c);
    endfunction

    // coordinate inside the image, biased toward the edges of large images
    function automatic logic [15:0] edge_coord(int size);
        if (size < 8 || $urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, size - 1));
        return ($urandom_range(0, 1) ? 16'($urandom_range(0, 3))
                                     : 16'($urandom_range(size - 4, size - 1)));
    endfunction

    function automatic logic [16:0] pick_pos();
        unique case ($urandom_range(0, 5))
            0:       return 17'($urandom_range(0, 1023));
            1:       return 17'($urandom_range(64512, 65536));
            2:       return 17'($urandom_range(65537, 131071));
            3:       return ($urandom_range(0, 1) ? 17'd0 : 17'd65536);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic bts_pkg::req_t texel_write(logic [15:0] x, logic [15:0] y);
        bts_pkg::req_t r;
        r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
        r.req_type = bts_pkg::REQ_WRITE;
        r.pixel_x = x;
        r.pixel_y = y;
        return r;
    endfunction

    // random request that never reads a texel that was never written
    function automatic bts_pkg::req_t random_request();
        bts_pkg::req_t r;
        int roll, x1, x2, y1, y2;
        for (int tries = 0; tries < 30; tries++)
        begin
            r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                if ($urandom_range(0, 6) != 0)
                begin
                    r.pixel_x = edge_coord(cur_w);
                    r.pixel_y = edge_coord(cur_h);
                end
                r.req_type = bts_pkg::REQ_WRITE;
                return r;
            end
            else if (roll < 60)
            begin
                r.req_type = bts_pkg::REQ_READ;
                if ($urandom_range(0, 1))
                begin
                    r.pixel_x = edge_coord(cur_w);
                    r.pixel_y = edge_coord(cur_h);
                end
                if (is_set(clamp_to(r.pixel_x, cur_w), clamp_to(r.pixel_y, cur_h)))
                    return r;
            end
            else if (roll < 95)
            begin
                r.req_type = bts_pkg::REQ_SAMPLE;
                r.sample_u = pick_pos();
                r.sample_v = pick_pos();
                axis_span(r.sample_u, cur_w, x1, x2);
                axis_span(r.sample_v, cur_h, y1, y2);
                if (is_set(x1, y1) && is_set(x2, y1) && is_set(x1, y2) && is_set(x2, y2))
                    return r;
            end
            else
            begin
                r.req_type = bts_pkg::REQ_RESERVED;
                return r;
            end
        end
        return texel_write(edge_coord(cur_w), edge_coord(cur_h));
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one request until accepted, then an optional gap
    task automatic send_request(bts_pkg::req_t r);
        bit taken;
        int gap;
        req <= r;
        req_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end while (!taken);
        if (r.req_type == bts_pkg::REQ_WRITE && r.pixel_x >= 0 && r.pixel_y >= 0 &&
            int'(r.pixel_x) < cur_w && int'(r.pixel_y) < cur_h)
            texel_set[int'(r.pixel_y) * 256 + int'(r.pixel_x)] = 1'b1;
        gap = gap_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_register(logic [0:0] idx, logic [8:0] value);
        bit taken;
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
        cfg_valid <= 1'b0;
    endtask

    // drain outstanding results, then set a new image size
    task automatic resize(int w, int h);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        write_register(bts_pkg::CFG_WIDTH, w[8:0]);
        write_register(bts_pkg::CFG_HEIGHT, h[8:0]);
        cur_w = size_of(w, 256);
        cur_h = size_of(h, 256);
    endtask

    function automatic bts_pkg::req_t sample_at(logic [16:0] u, logic [16:0] v);
        bts_pkg::req_t r;
        r = '0;
        r.req_type = bts_pkg::REQ_SAMPLE;
        r.sample_u = u;
        r.sample_v = v;
        return r;
    endfunction

    function automatic bts_pkg::req_t read_at(logic [15:0] x, logic [15:0] y);
        bts_pkg::req_t r;
        r = '0;
        r.req_type = bts_pkg::REQ_READ;
        r.pixel_x = x;
        r.pixel_y = y;
        return r;
    endfunction

    initial
    begin
        int widths [8]  = '{4, 256, 1, 0, 511, 3, 256, 17};
        int heights [8] = '{4, 256, 1, 0, 300, 256, 2, 9};
        bts_pkg::req_t r;
        rst_n = 1'b0;
        req = '0;
        req_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_gaps = 1'b0;
        cur_w = 256;
        cur_h = 256;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 2x2 image with extreme texels, clamping and saturation
        resize(2, 2);
        r = texel_write(16'd0, 16'd0);
        {r.write_alpha, r.write_blue, r.write_green, r.write_red} = 32'h0000_0000;
        send_request(r);
        r = texel_write(16'd1, 16'd0);
        {r.write_alpha, r.write_blue, r.write_green, r.write_red} = 32'hFFFF_FFFF;
        send_request(r);
        r = texel_write(16'd0, 16'd1);
        {r.write_alpha, r.write_blue, r.write_green, r.write_red} = 32'hFF00_FF00;
        send_request(r);
        r = texel_write(16'd1, 16'd1);
        {r.write_alpha, r.write_blue, r.write_green, r.write_red} = 32'h0180_7FFE;
        send_request(r);
        // writes outside the image are dropped
        send_request(texel_write(16'hFFFF, 16'd0));
        send_request(texel_write(16'd2, 16'd0));
        send_request(texel_write(16'h7FFF, 16'h8000));
        send_request(read_at(16'h8000, 16'h8000));
        send_request(read_at(16'h7FFF, 16'h7FFF));
        send_request(read_at(16'd1, 16'd0));
        send_request(sample_at(17'd0, 17'd0));
        send_request(sample_at(17'd65536, 17'd65536));
        send_request(sample_at(17'h1FFFF, 17'h1FFFF));
        send_request(sample_at(17'd32768, 17'd32768));
        send_request(sample_at(17'd32768, 17'd0));
        send_request(sample_at(17'd40000, 17'd20000));
        r = random_request();
        r.req_type = bts_pkg::REQ_RESERVED;
        send_request(r);

        // random phases over image sizes
        for (int p = 0; p < 8; p++)
        begin
            resize(widths[p], heights[p]);
            no_gaps = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < 215; n++)
            begin
                if (p == 2 && n == 40) hold_off = 1'b1;
                send_request(random_request());
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/bts_pkg.sv
hw/rtl/bts_front.sv
hw/rtl/bts_back.sv
hw/rtl/bilinear_texel_sampler.sv
sim/bts_checker.sv
sim/tb.sv
